>>> hdl/stx_dfr_pkg.sv
// ----------------------------------------------------------------------------
// STX deframer package
// Shared widths, codes and types of the STX / BCD length / LRC deframer.
// ----------------------------------------------------------------------------
package stx_dfr_pkg;

   // Field widths.
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 14;
   localparam int TICK_W     = 16;
   localparam int KIND_W     = 2;
   localparam int NIB_W      = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Framing constants.
   localparam logic [BYTE_W-1:0] START_BYTE  = 8'h02;
   localparam logic [LEN_W-1:0]  LEN_CAP     = 14'd9999;
   localparam logic [NIB_W-1:0]  DIGIT_MAX   = 4'd9;
   localparam logic [LEN_W-1:0]  MAX_LEN_RST = 14'd8192;

   // Input opcodes.
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // Result kinds.
   typedef enum logic [KIND_W-1:0] {
      K_PAYLOAD = 2'd0,
      K_GOOD    = 2'd1,
      K_ERROR   = 2'd2,
      K_TIMEOUT = 2'd3
   } kind_type;

   // Receiver phases.
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_ETX     = 3'd4,
      PH_LRC     = 3'd5
   } phase_type;

   // Register indexes (byte address / 4).
   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_MIN_LEN = 2'd0,
      REG_MAX_LEN = 2'd1,
      REG_TIMEOUT = 2'd2
   } reg_index_type;

   // Register values handed to the receiver.
   typedef struct packed {
      logic [LEN_W-1:0]  min_len;
      logic [LEN_W-1:0]  max_len;
      logic [TICK_W-1:0] timeout;
   } cfg_type;

endpackage

>>> hdl/stx_dfr_if.sv
// ----------------------------------------------------------------------------
// STX deframer channels
// Valid/ready channels for incoming bytes and ticks and for results.
// ----------------------------------------------------------------------------
interface stx_dfr_req_if import stx_dfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, opcode, rx_byte, input ready);
   modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface stx_dfr_rsp_if import stx_dfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic [LEN_W-1:0]    frame_length;

   modport source (output valid, kind, payload_byte, frame_length, input ready);
   modport sink   (input valid, kind, payload_byte, frame_length, output ready);
endinterface

>>> hdl/stx_dfr_regs.sv
// ----------------------------------------------------------------------------
// STX deframer registers
// APB-style register file holding the length bounds and the tick timeout.
// ----------------------------------------------------------------------------
module stx_dfr_regs import stx_dfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   // Write decode; an address beyond the register list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_MIN_LEN: cfg_in.min_len = pwdata[LEN_W-1:0];
            REG_MAX_LEN: cfg_in.max_len = pwdata[LEN_W-1:0];
            REG_TIMEOUT: cfg_in.timeout = pwdata[TICK_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_len <= '0;
         cfg_ff.max_len <= MAX_LEN_RST;
         cfg_ff.timeout <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (index)
         REG_MIN_LEN: prdata = CSR_DATA_W'(cfg_ff.min_len);
         REG_MAX_LEN: prdata = CSR_DATA_W'(cfg_ff.max_len);
         REG_TIMEOUT: prdata = CSR_DATA_W'(cfg_ff.timeout);
         default:     prdata = '0;
      endcase
   end

endmodule

>>> hdl/stx_bcd_length_lrc_deframer_top.sv
// ----------------------------------------------------------------------------
// STX / BCD length / LRC deframer
// Hunts for STX, decodes a BCD payload length, streams the payload and
// closes each frame as good, error or timeout.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Contents
//  req_ch    in         valid/ready             opcode, rx_byte
//  rsp_ch    out        valid/ready             kind, payload_byte, frame_length
//  csr       in/out     psel/penable, pready=1  three registers at 0x0, 0x4, 0x8
//
//  One transaction is taken per cycle while req_ch.ready is high; its single
//  state update is done in the cycle of acceptance and any result lands in
//  the output register, which drives rsp_ch from the cycle after acceptance.
//  Synchronous reset clears all control state and the CSRs, but sets max_len to 8192.
//  A stalled result holds req_ch.ready low only while it is not being taken.
// ----------------------------------------------------------------------------
module stx_bcd_length_lrc_deframer_top import stx_dfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   stx_dfr_req_if.sink           req_ch,
   stx_dfr_rsp_if.source         rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;

   stx_dfr_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Receiver state.
   phase_type          phase_ff,  phase_in;
   logic [BYTE_W-1:0]  len_hi_ff, len_hi_in;
   logic [LEN_W-1:0]   plen_ff,   plen_in;
   logic [LEN_W-1:0]   seen_ff,   seen_in;
   logic [BYTE_W-1:0]  lrc_ff,    lrc_in;
   logic [TICK_W-1:0]  ticks_ff,  ticks_in;

   // Output register.
   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff,  rsp_kind_in;
   logic [BYTE_W-1:0]  rsp_byte_ff,  rsp_byte_in;
   logic [LEN_W-1:0]   rsp_len_ff,   rsp_len_in;
   logic               emit;

   logic               accept;
   logic [BYTE_W-1:0]  rx;
   logic [NIB_W-1:0]   d0, d1, d2, d3;
   logic               bcd_ok;
   logic [LEN_W-1:0]   dec_len;
   logic [LEN_W-1:0]   max_eff;
   logic [LEN_W-1:0]   seen_inc;
   logic [TICK_W-1:0]  ticks_inc;

   // The input side moves whenever the output register is free or draining.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rx           = req_ch.rx_byte;

   // BCD length decode from the stored high byte and the incoming low byte.
   assign d0      = rx[NIB_W-1:0];
   assign d1      = rx[BYTE_W-1:NIB_W];
   assign d2      = len_hi_ff[NIB_W-1:0];
   assign d3      = len_hi_ff[BYTE_W-1:NIB_W];
   assign bcd_ok  = (d0 <= DIGIT_MAX) && (d1 <= DIGIT_MAX) &&
                    (d2 <= DIGIT_MAX) && (d3 <= DIGIT_MAX);
   assign dec_len = LEN_W'(d3) * LEN_W'(1000) + LEN_W'(d2) * LEN_W'(100) +
                    LEN_W'(d1) * LEN_W'(10) + LEN_W'(d0);
   assign max_eff = (cfg.max_len > LEN_CAP) ? LEN_CAP : cfg.max_len;

   assign seen_inc  = seen_ff + LEN_W'(1);
   assign ticks_inc = (ticks_ff == '1) ? ticks_ff : ticks_ff + TICK_W'(1);

   // Next state and result for the accepted transaction.
   always_comb begin
      phase_in    = phase_ff;
      len_hi_in   = len_hi_ff;
      plen_in     = plen_ff;
      seen_in     = seen_ff;
      lrc_in      = lrc_ff;
      ticks_in    = ticks_ff;
      emit        = 1'b0;
      rsp_kind_in = K_PAYLOAD;
      rsp_byte_in = '0;
      rsp_len_in  = '0;
      if (accept) begin
         if (opcode_type'(req_ch.opcode) == OP_TICK) begin
            // Ticks count only inside a frame and only with the timeout enabled.
            if (phase_ff != PH_HUNT && cfg.timeout != '0) begin
               ticks_in = ticks_inc;
               if (ticks_inc >= cfg.timeout) begin
                  phase_in    = PH_HUNT;
                  ticks_in    = '0;
                  emit        = 1'b1;
                  rsp_kind_in = K_TIMEOUT;
                  rsp_len_in  = plen_ff;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (rx == START_BYTE) begin
                     phase_in  = PH_LEN_HI;
                     len_hi_in = '0;
                     plen_in   = '0;
                     seen_in   = '0;
                     lrc_in    = '0;
                     ticks_in  = '0;
                  end
               end
               PH_LEN_HI: begin
                  len_hi_in = rx;
                  lrc_in    = lrc_ff ^ rx;
                  phase_in  = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  lrc_in = lrc_ff ^ rx;
                  if (!bcd_ok) begin
                     phase_in    = PH_HUNT;
                     ticks_in    = '0;
                     emit        = 1'b1;
                     rsp_kind_in = K_ERROR;
                  end else begin
                     plen_in = dec_len;
                     if (dec_len < cfg.min_len || dec_len > max_eff) begin
                        phase_in    = PH_HUNT;
                        ticks_in    = '0;
                        emit        = 1'b1;
                        rsp_kind_in = K_ERROR;
                        rsp_len_in  = dec_len;
                     end else begin
                        seen_in  = '0;
                        phase_in = (dec_len == '0) ? PH_ETX : PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  lrc_in      = lrc_ff ^ rx;
                  seen_in     = seen_inc;
                  if (seen_inc >= plen_ff) begin
                     phase_in = PH_ETX;
                  end
                  emit        = 1'b1;
                  rsp_kind_in = K_PAYLOAD;
                  rsp_byte_in = rx;
               end
               PH_ETX: begin
                  lrc_in   = lrc_ff ^ rx;
                  phase_in = PH_LRC;
               end
               PH_LRC: begin
                  phase_in    = PH_HUNT;
                  ticks_in    = '0;
                  emit        = 1'b1;
                  rsp_kind_in = (rx == lrc_ff) ? K_GOOD : K_ERROR;
                  rsp_len_in  = plen_ff;
               end
               default: begin
                  phase_in = PH_HUNT;
                  ticks_in = '0;
               end
            endcase
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         len_hi_ff <= '0;
         plen_ff   <= '0;
         seen_ff   <= '0;
         lrc_ff    <= '0;
         ticks_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         len_hi_ff <= len_hi_in;
         plen_ff   <= plen_in;
         seen_ff   <= seen_in;
         lrc_ff    <= lrc_in;
         ticks_ff  <= ticks_in;
      end
   end

   // Result register: loaded on a new result, cleared once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_len_ff  <= rsp_len_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.payload_byte = rsp_byte_ff;
   assign rsp_ch.frame_length = rsp_len_ff;

`ifndef ASSERT_OFF
   // The tick counter is idle while hunting.
   a_hunt_ticks_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> ticks_ff == '0)
      else $error("tick counter running while hunting");

   // Inside the payload the byte count stays below the decoded length.
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> seen_ff < plen_ff)
      else $error("payload count reached length inside payload phase");

   // Payload results carry no length; end results carry no byte.
   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff == K_PAYLOAD ? rsp_len_ff == '0
                                                 : rsp_byte_ff == '0))
      else $error("result carries a field that its kind leaves zero");

   // The input side stalls only behind a pending result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif

endmodule
